/* src/lgrs_pkg.sv */
// Shared constants, config indexes and result beat type for the row stepper.
// No dependencies; every other file uses it by scoped names.
package lgrs_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 1024;
  localparam int LANE_COLS   = 8;
  localparam int NUM_LANES   = MAX_COLUMNS / LANE_COLS;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam int ROW_W    = 64;
  localparam int ROWNUM_W = 10;
  localparam int GW_W     = 7;
  localparam int GH_W     = 11;
  localparam int CFG_W    = 11;

  localparam logic [GW_W-1:0] GW_RESET = 7'd40;
  localparam logic [GH_W-1:0] GH_RESET = 11'd20;
  localparam logic [GW_W-1:0] GW_MIN   = 7'd3;
  localparam logic [GW_W-1:0] GW_MAX   = GW_W'(MAX_COLUMNS);
  localparam logic [GH_W-1:0] GH_MIN   = 11'd3;
  localparam logic [GH_W-1:0] GH_MAX   = GH_W'(MAX_ROWS);

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [ROW_W-1:0]    cells;
    logic [ROWNUM_W-1:0] row_number;
    logic                last_of_run;
  } result_t;

  typedef struct packed {
    logic not_empty;
    logic room_two;
  } fifo_status_t;

endpackage

/* src/life_generation_row_stepper_top.sv */
// Top level of the B3/S23 row stepper: row window, lanes, merge, result queue.
// Depends on lgrs_pkg, lgrs_lane, lgrs_merge, lgrs_result_fifo.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+----------------------
//  in      | in_row_cells[63:0]                               | in_valid / in_stall
//  out     | out_next_row_cells, out_row_number, out_last_of_run | out_valid / out_stall
//  cfg     | cfg_index (0 width, 1 height), cfg_wdata[10:0]   | cfg_we, no wait
//
// One input row is taken per cycle while in_stall is low; its results are written
// into the queue at the same edge that takes the row, so out_valid is high in the
// next cycle and the first result beat can leave in that cycle (the second row of
// a frame makes no beat). The frame's last row makes two result beats, and the
// output port drains one beat a cycle while out_stall is low. A 4-beat queue parts
// the sides: in_stall is high while fewer than two slots are free. Sync active-low
// reset empties the queue, clears the row window and loads width 40, height 20.
// Stalls on the output hold the queue head; the input keeps flowing until fewer
// than two slots are free.
module life_generation_row_stepper_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lgrs_pkg::ROW_W-1:0]    in_row_cells,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lgrs_pkg::ROW_W-1:0]    out_next_row_cells,
  output logic [lgrs_pkg::ROWNUM_W-1:0] out_row_number,
  output logic                          out_last_of_run,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [lgrs_pkg::CFG_W-1:0]    cfg_wdata
);

  // config registers
  logic [lgrs_pkg::GW_W-1:0] grid_width_r;
  logic [lgrs_pkg::GH_W-1:0] grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lgrs_pkg::GW_RESET;
      grid_height_r <= lgrs_pkg::GH_RESET;
    end else if (cfg_we) begin
      case (lgrs_pkg::cfg_index_t'(cfg_index))
        lgrs_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[lgrs_pkg::GW_W-1:0];
        lgrs_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[lgrs_pkg::GH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the legal ranges
  logic [lgrs_pkg::GW_W-1:0] eff_w;
  logic [lgrs_pkg::GH_W-1:0] eff_h;

  always_comb begin
    if (grid_width_r < lgrs_pkg::GW_MIN)      eff_w = lgrs_pkg::GW_MIN;
    else if (grid_width_r > lgrs_pkg::GW_MAX) eff_w = lgrs_pkg::GW_MAX;
    else                                      eff_w = grid_width_r;
    if (grid_height_r < lgrs_pkg::GH_MIN)      eff_h = lgrs_pkg::GH_MIN;
    else if (grid_height_r > lgrs_pkg::GH_MAX) eff_h = lgrs_pkg::GH_MAX;
    else                                       eff_h = grid_height_r;
  end

  logic [lgrs_pkg::ROW_W-1:0] width_mask;
  always_comb begin
    for (int k = 0; k < lgrs_pkg::ROW_W; k++) begin
      width_mask[k] = (lgrs_pkg::GW_W'(k) < eff_w);
    end
  end

  // row window
  logic [lgrs_pkg::ROW_W-1:0]    row_above_r, row_above_nxt;
  logic [lgrs_pkg::ROW_W-1:0]    row_middle_r, row_middle_nxt;
  logic [lgrs_pkg::ROWNUM_W-1:0] rows_r, rows_nxt;

  logic                          in_take, out_take;
  logic [lgrs_pkg::ROW_W-1:0]    x_row;
  logic                          frame_end;
  lgrs_pkg::fifo_status_t        fifo_st;

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign x_row     = in_row_cells & width_mask;
  // last row once r + 1 reaches the height
  assign frame_end = ({1'b0, rows_r} + lgrs_pkg::GH_W'(1)) >= eff_h;

  // lanes: each sees its 8 columns plus one halo column either side
  logic [lgrs_pkg::ROW_W+1:0] up_pad, mid_pad, down_pad;
  logic [lgrs_pkg::ROW_W-1:0] lane_cells, gen_row;

  assign up_pad   = {1'b0, row_above_r, 1'b0};
  assign mid_pad  = {1'b0, row_middle_r, 1'b0};
  assign down_pad = {1'b0, x_row, 1'b0};

  for (genvar g = 0; g < lgrs_pkg::NUM_LANES; g++) begin : g_lane
    lgrs_lane u_lane (
      .up         (up_pad[g*lgrs_pkg::LANE_COLS +: lgrs_pkg::LANE_COLS+2]),
      .mid        (mid_pad[g*lgrs_pkg::LANE_COLS +: lgrs_pkg::LANE_COLS+2]),
      .down       (down_pad[g*lgrs_pkg::LANE_COLS +: lgrs_pkg::LANE_COLS+2]),
      .next_cells (lane_cells[g*lgrs_pkg::LANE_COLS +: lgrs_pkg::LANE_COLS])
    );
  end

  lgrs_merge u_merge (
    .lane_cells (lane_cells),
    .mid_row    (row_middle_r),
    .eff_width  (eff_w),
    .next_row   (gen_row)
  );

  // result beats for this row
  logic [1:0]        wr_cnt;
  lgrs_pkg::result_t beat0, beat1, head;

  always_comb begin
    row_above_nxt  = row_above_r;
    row_middle_nxt = row_middle_r;
    rows_nxt       = rows_r;
    wr_cnt         = 2'd0;
    beat0.cells       = gen_row;
    beat0.row_number  = rows_r - lgrs_pkg::ROWNUM_W'(1);
    beat0.last_of_run = !frame_end;
    beat1.cells       = x_row;
    beat1.row_number  = rows_r;
    beat1.last_of_run = 1'b1;
    if (in_take) begin
      if (rows_r == '0) begin
        // top frame row goes out as is
        wr_cnt            = 2'd1;
        beat0.cells       = x_row;
        beat0.row_number  = '0;
        beat0.last_of_run = 1'b1;
        row_above_nxt     = '0;
        row_middle_nxt    = x_row;
        rows_nxt          = lgrs_pkg::ROWNUM_W'(1);
      end else if (rows_r == lgrs_pkg::ROWNUM_W'(1)) begin
        row_above_nxt  = row_middle_r;
        row_middle_nxt = x_row;
        rows_nxt       = lgrs_pkg::ROWNUM_W'(2);
      end else if (frame_end) begin
        // bottom frame row follows the generated row; window restarts
        wr_cnt         = 2'd2;
        row_above_nxt  = '0;
        row_middle_nxt = '0;
        rows_nxt       = '0;
      end else begin
        wr_cnt         = 2'd1;
        row_above_nxt  = row_middle_r;
        row_middle_nxt = x_row;
        rows_nxt       = rows_r + lgrs_pkg::ROWNUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r  <= '0;
      row_middle_r <= '0;
      rows_r       <= '0;
    end else begin
      row_above_r  <= row_above_nxt;
      row_middle_r <= row_middle_nxt;
      rows_r       <= rows_nxt;
    end
  end

  lgrs_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_data0 (beat0),
    .wr_data1 (beat1),
    .rd_take  (out_take),
    .rd_data  (head),
    .status   (fifo_st)
  );

  assign in_stall           = !fifo_st.room_two;
  assign out_valid          = fifo_st.not_empty;
  assign out_next_row_cells = head.cells;
  assign out_row_number     = head.row_number;
  assign out_last_of_run    = head.last_of_run;

  // checks
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("queued beat lost under output stall");

  a_first_row_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (rows_r == '0) |=> (rows_r == lgrs_pkg::ROWNUM_W'(1)) && out_valid)
    else $error("top row not queued or window not advanced");

  a_second_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (rows_r == lgrs_pkg::ROWNUM_W'(1)) && !out_take && !out_valid
    |=> !out_valid)
    else $error("second row produced a beat");

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && (rows_r > lgrs_pkg::ROWNUM_W'(1)) && frame_end |=> (rows_r == '0))
    else $error("window not cleared after last row");

  a_row_below_height: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !frame_end |-> ({1'b0, rows_r} < eff_h))
    else $error("row count past frame height");

endmodule

/* src/lgrs_lane.sv */
// One lane: B3/S23 rule for LANE_COLS adjacent cells.
// Takes a halo slice of the three rows; uses lgrs_pkg.
module lgrs_lane (
  input  logic [lgrs_pkg::LANE_COLS+1:0] up,
  input  logic [lgrs_pkg::LANE_COLS+1:0] mid,
  input  logic [lgrs_pkg::LANE_COLS+1:0] down,
  output logic [lgrs_pkg::LANE_COLS-1:0] next_cells
);

  logic [3:0] nbr [lgrs_pkg::LANE_COLS];

  always_comb begin
    for (int k = 0; k < lgrs_pkg::LANE_COLS; k++) begin
      nbr[k] = 4'(up[k]) + 4'(up[k+1]) + 4'(up[k+2])
             + 4'(mid[k]) + 4'(mid[k+2])
             + 4'(down[k]) + 4'(down[k+1]) + 4'(down[k+2]);
      // birth on 3, survival on 2 or 3
      next_cells[k] = (nbr[k] == 4'd3) || (mid[k+1] && (nbr[k] == 4'd2));
    end
  end

endmodule

/* src/lgrs_merge.sv */
// Merge stage: joins lane results, copies frame columns, masks to width.
// Uses lgrs_pkg.
module lgrs_merge (
  input  logic [lgrs_pkg::ROW_W-1:0] lane_cells,
  input  logic [lgrs_pkg::ROW_W-1:0] mid_row,
  input  logic [lgrs_pkg::GW_W-1:0]  eff_width,
  output logic [lgrs_pkg::ROW_W-1:0] next_row
);

  logic [lgrs_pkg::GW_W-1:0] last_col;

  assign last_col = eff_width - lgrs_pkg::GW_W'(1);

  always_comb begin
    for (int k = 0; k < lgrs_pkg::ROW_W; k++) begin
      if (lgrs_pkg::GW_W'(k) >= eff_width) begin
        next_row[k] = 1'b0;
      end else if ((k == 0) || (lgrs_pkg::GW_W'(k) >= last_col)) begin
        next_row[k] = mid_row[k];
      end else begin
        next_row[k] = lane_cells[k];
      end
    end
  end

endmodule

/* src/lgrs_result_fifo.sv */
// Result queue: takes up to two beats per cycle, hands out one when rd_take is high.
// Uses lgrs_pkg result_t and fifo_status_t.
module lgrs_result_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             wr_cnt,
  input  lgrs_pkg::result_t      wr_data0,
  input  lgrs_pkg::result_t      wr_data1,
  input  logic                   rd_take,
  output lgrs_pkg::result_t      rd_data,
  output lgrs_pkg::fifo_status_t status
);

  lgrs_pkg::result_t mem [lgrs_pkg::FIFO_DEPTH];

  logic [lgrs_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lgrs_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lgrs_pkg::CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + lgrs_pkg::PTR_W'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + lgrs_pkg::PTR_W'(rd_take);
    count_nxt  = count_r + lgrs_pkg::CNT_W'(wr_cnt) - lgrs_pkg::CNT_W'(rd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wr_ptr_r] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wr_ptr_r + lgrs_pkg::PTR_W'(1)] <= wr_data1;
    end
  end

  assign rd_data          = mem[rd_ptr_r];
  assign status.not_empty = (count_r != '0);
  assign status.room_two  = (count_r <= lgrs_pkg::CNT_W'(lgrs_pkg::FIFO_DEPTH - 2));

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for the B3/S23 row stepper: streams grid rows, predicts each result beat.
// Depends on lgrs_pkg and life_generation_row_stepper_top.

module testbench;

  localparam int RANDOM_ROWS  = 300;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // Shadow of the stepper: register copies, the two-row window, the per-frame
  // row count, and the queue of result beats still owed by the block.
  class generation_scoreboard;
    logic [lgrs_pkg::GW_W-1:0]  width_reg;
    logic [lgrs_pkg::GH_W-1:0]  height_reg;
    logic [lgrs_pkg::ROW_W-1:0] row_prev;
    logic [lgrs_pkg::ROW_W-1:0] row_cur;
    int unsigned                rows_in;
    lgrs_pkg::result_t          pending_rows[$];
    int unsigned                mismatches;

    function new();
      width_reg  = lgrs_pkg::GW_RESET;
      height_reg = lgrs_pkg::GH_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      row_prev = '0;
      row_cur  = '0;
      rows_in  = 0;
    endfunction

    function void write_reg(lgrs_pkg::cfg_index_t idx, logic [lgrs_pkg::CFG_W-1:0] value);
      if (idx == lgrs_pkg::CFG_GRID_WIDTH) width_reg = value[lgrs_pkg::GW_W-1:0];
      else height_reg = value[lgrs_pkg::GH_W-1:0];
    endfunction

    // clamp to the legal range
    function int cols();
      if (width_reg < lgrs_pkg::GW_MIN) return int'(lgrs_pkg::GW_MIN);
      if (width_reg > lgrs_pkg::GW_MAX) return int'(lgrs_pkg::GW_MAX);
      return int'(width_reg);
    endfunction

    function int frame_rows();
      if (height_reg < lgrs_pkg::GH_MIN) return int'(lgrs_pkg::GH_MIN);
      if (height_reg > lgrs_pkg::GH_MAX) return int'(lgrs_pkg::GH_MAX);
      return int'(height_reg);
    endfunction

    function logic [lgrs_pkg::ROW_W-1:0] span_mask(int w);
      if (w >= lgrs_pkg::ROW_W) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    // next generation of the middle row; frame columns pass through
    function logic [lgrs_pkg::ROW_W-1:0] next_gen_row(logic [lgrs_pkg::ROW_W-1:0] up,
                                                      logic [lgrs_pkg::ROW_W-1:0] mid,
                                                      logic [lgrs_pkg::ROW_W-1:0] down,
                                                      int w);
      logic [lgrs_pkg::ROW_W-1:0] res;
      int n;
      res = mid & span_mask(w);
      for (int k = 1; k + 1 < w; k++) begin
        n = 0;
        for (int d = -1; d <= 1; d++) begin
          n += int'(up[k+d]);
          n += int'(down[k+d]);
        end
        n += int'(mid[k-1]);
        n += int'(mid[k+1]);
        res[k] = mid[k] ? (n == 2 || n == 3) : (n == 3);
      end
      return res;
    endfunction

    function void note_row(logic [lgrs_pkg::ROW_W-1:0] row);
      int w;
      int h;
      logic [lgrs_pkg::ROW_W-1:0] x;
      lgrs_pkg::result_t e;
      w = cols();
      h = frame_rows();
      x = row & span_mask(w);
      if (rows_in == 0) begin
        e.cells       = x;
        e.row_number  = '0;
        e.last_of_run = 1'b1;
        pending_rows.push_back(e);
        row_prev = '0;
        row_cur  = x;
        rows_in  = 1;
      end else if (rows_in == 1) begin
        row_prev = row_cur;
        row_cur  = x;
        rows_in  = 2;
      end else begin
        e.cells      = next_gen_row(row_prev, row_cur, x, w);
        e.row_number = lgrs_pkg::ROWNUM_W'(rows_in - 1);
        if (int'(rows_in) + 1 >= h) begin
          e.last_of_run = 1'b0;
          pending_rows.push_back(e);
          e.cells       = x;
          e.row_number  = lgrs_pkg::ROWNUM_W'(rows_in);
          e.last_of_run = 1'b1;
          pending_rows.push_back(e);
          clear_frame();
        end else begin
          e.last_of_run = 1'b1;
          pending_rows.push_back(e);
          row_prev = row_cur;
          row_cur  = x;
          rows_in  = (rows_in + 1) % 1024;
        end
      end
    endfunction

    function void check_beat(logic [lgrs_pkg::ROW_W-1:0] cells,
                             logic [lgrs_pkg::ROWNUM_W-1:0] num, logic last);
      lgrs_pkg::result_t e;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: cells=%h row=%0d last=%b", cells, num, last);
        return;
      end
      e = pending_rows.pop_front();
      if (e.cells !== cells || e.row_number !== num || e.last_of_run !== last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: exp cells=%h row=%0d last=%b / got cells=%h row=%0d last=%b",
                   e.cells, e.row_number, e.last_of_run, cells, num, last);
      end
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction
  endclass

  // Clock and block ports; every input starts at a known value.
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [lgrs_pkg::ROW_W-1:0]    in_row_cells = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [lgrs_pkg::ROW_W-1:0]    out_next_row_cells;
  logic [lgrs_pkg::ROWNUM_W-1:0] out_row_number;
  logic                          out_last_of_run;
  logic                          cfg_we = 1'b0;
  logic [0:0]                    cfg_index = '0;
  logic [lgrs_pkg::CFG_W-1:0]    cfg_wdata = '0;

  generation_scoreboard sb;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  life_generation_row_stepper_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_row_cells      (in_row_cells),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_next_row_cells(out_next_row_cells),
    .out_row_number    (out_row_number),
    .out_last_of_run   (out_last_of_run),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver stall pattern: whenever the current stretch runs out, pick a new
  // mode - free flowing, light random, heavy random, or alternating. Heavy
  // stretches fill the 4-beat queue and push back on the input side.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  // Result monitor: a beat moves on any edge with valid high and stall low.
  // Signals are read just after the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_beat(out_next_row_cells, out_row_number, out_last_of_run);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One input beat: payload held until the block takes it, noted on acceptance.
  task automatic send_row(input logic [lgrs_pkg::ROW_W-1:0] row);
    in_valid     <= 1'b1;
    in_row_cells <= row;
    do @(posedge clk); while (in_stall);
    sb.note_row(row);
  endtask

  // Sender bursts: random burst lengths, with a random idle gap or none between.
  // A zero gap glues bursts together into long unbroken stretches.
  task automatic paced_row(input logic [lgrs_pkg::ROW_W-1:0] row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_row(row);
  endtask

  // Wait for every owed beat, then for the drain delay: the second row of a
  // frame leaves no beat behind but may still be updating the window.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input lgrs_pkg::cfg_index_t idx,
                           input logic [lgrs_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_grid(input logic [lgrs_pkg::CFG_W-1:0] w,
                              input logic [lgrs_pkg::CFG_W-1:0] h);
    write_cfg(lgrs_pkg::CFG_GRID_WIDTH, w);
    write_cfg(lgrs_pkg::CFG_GRID_HEIGHT, h);
  endtask

  // Random row with a varying density; bits above the width are left as
  // noise, since the block has to mask them.
  function automatic logic [lgrs_pkg::ROW_W-1:0] rand_cells();
    logic [lgrs_pkg::ROW_W-1:0] a;
    logic [lgrs_pkg::ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return a & b;
      5, 6: return a | b;
      default: return a;
    endcase
  endfunction

  // Raw register values, out-of-range ones included; unused width bits are noise.
  function automatic logic [lgrs_pkg::CFG_W-1:0] pick_width();
    logic [lgrs_pkg::GW_W-1:0] w;
    case ($urandom_range(0, 9))
      0: w = lgrs_pkg::GW_W'($urandom_range(0, 2));
      1: w = lgrs_pkg::GW_W'($urandom_range(65, 127));
      2: w = lgrs_pkg::GW_MIN;
      3: w = lgrs_pkg::GW_MAX;
      default: w = lgrs_pkg::GW_W'($urandom_range(3, 64));
    endcase
    return {4'($urandom), w};
  endfunction

  function automatic logic [lgrs_pkg::CFG_W-1:0] pick_height();
    case ($urandom_range(0, 19))
      0: return lgrs_pkg::CFG_W'($urandom_range(0, 2));
      1: return lgrs_pkg::CFG_W'($urandom_range(1025, 2047));
      2: return lgrs_pkg::GH_MAX;
      3, 4: return lgrs_pkg::GH_MIN;
      5, 6, 7: return lgrs_pkg::CFG_W'($urandom_range(13, 40));
      default: return lgrs_pkg::CFG_W'($urandom_range(4, 12));
    endcase
  endfunction

  initial begin
    int sent;
    int h;
    int n;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: smallest grid, one whole frame.
    program_grid(11'd3, 11'd3);
    paced_row('1);
    paced_row('0);
    paced_row('1);
    settle();

    // Width 127 clamps to 64 and height 0 to 3; a crowded middle row dies.
    program_grid(11'h07F, 11'd0);
    paced_row('1);
    paced_row(64'h5555_5555_5555_5555);
    paced_row('1);
    settle();

    // Vertical blinker in an 8x6 grid turns horizontal.
    program_grid(11'd8, 11'd6);
    paced_row(64'h0);
    paced_row(64'h8);
    paced_row(64'h8);
    paced_row(64'h8);
    paced_row(64'h0);
    paced_row(64'h0);
    settle();

    // Width 1 (upper data bits set) and height 2 both clamp to 3.
    program_grid(11'h081, 11'd2);
    repeat (3) paced_row(rand_cells());
    settle();

    // Shrink the height mid-frame: the next row closes the frame at once.
    program_grid(11'd64, 11'd10);
    repeat (5) paced_row(rand_cells());
    settle();
    write_cfg(lgrs_pkg::CFG_GRID_HEIGHT, 11'd4);
    paced_row(rand_cells());
    settle();

    // One full frame at the deepest height so every row number bit toggles;
    // 2047 clamps to 1024 rows.
    program_grid(11'd64, 11'd2047);
    n = sb.frame_rows() - int'(sb.rows_in);
    repeat (n) paced_row(rand_cells());
    settle();

    // Random phases: mostly runs that finish the current frame and a few
    // whole frames more, the rest partial runs that leave a frame open so
    // the next setting lands mid-frame.
    sent = 0;
    while (sent < RANDOM_ROWS) begin
      case ($urandom_range(0, 5))
        0: write_cfg(lgrs_pkg::CFG_GRID_WIDTH, pick_width());
        1: write_cfg(lgrs_pkg::CFG_GRID_HEIGHT, pick_height());
        default: program_grid(pick_width(), pick_height());
      endcase
      h = sb.frame_rows();
      if (h > 64) begin
        n = $urandom_range(1, 20);
      end else if ($urandom_range(0, 3) != 0) begin
        n = (int'(sb.rows_in) + 1 >= h) ? 1 : h - int'(sb.rows_in);
        n += h * $urandom_range(0, 2);
      end else begin
        n = $urandom_range(1, 2 * h);
      end
      repeat (n) paced_row(rand_cells());
      sent += n;
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* life_generation_row_stepper_top.f */
src/lgrs_pkg.sv
src/lgrs_lane.sv
src/lgrs_merge.sv
src/lgrs_result_fifo.sv
src/life_generation_row_stepper_top.sv
tb/sv/testbench.sv
